// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the polynomial term parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define PTP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed in polynomial term parser");
// Check that a condition in one cycle implies another in the next.
`define PTP_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
    else $error("assertion failed in polynomial term parser");
`else
`define PTP_ASSERT(lbl, clk, rstn, prop)
`define PTP_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

// ===== rtl/ptp_pkg.sv =====
// Package: types, character codes and defaults of the polynomial term parser.
package ptp_pkg;

  localparam int COEF_BITS_DEF  = 16;
  localparam int POWER_BITS_DEF = 6;
  localparam int DIGIT_BITS     = 8;
  localparam int LANES          = 4;

  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_Z  = 8'h5a;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_Z  = 8'h7a;
  localparam logic [7:0] CHAR_X     = 8'h78;
  localparam logic [7:0] CHAR_Y     = 8'h79;
  localparam logic [7:0] CHAR_Z     = 8'h7a;
  localparam logic [7:0] CHAR_R     = 8'h72;
  localparam logic [7:0] CHAR_SLASH = 8'h2f;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;

  typedef enum logic [2:0] {
    LETTER_NONE  = 3'd0,
    LETTER_X     = 3'd1,
    LETTER_Y     = 3'd2,
    LETTER_Z     = 3'd3,
    LETTER_R     = 3'd4,
    LETTER_OTHER = 3'd5
  } letter_e;

  typedef struct packed {
    logic in_num;
    logic in_den;
    logic at_start;
  } mode_t;

  typedef struct packed {
    logic num;
    logic den;
    logic pow;
  } seen_t;

  typedef struct packed {
    logic emit;
    logic final_term;
  } step_ctrl_t;

  localparam mode_t MODE_RESET = '{in_num: 1'b1, in_den: 1'b0, at_start: 1'b1};

endpackage

// ===== rtl/ptp_if.sv =====
// Valid/ready channel interfaces for characters in and terms out.
interface ptp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       final_char;

  modport source (output valid, character, final_char, input ready);
  modport sink (input valid, character, final_char, output ready);
endinterface

interface ptp_out_if
  import ptp_pkg::*;
#(
  parameter int COEF_BITS  = COEF_BITS_DEF,
  parameter int POWER_BITS = POWER_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  negative;
  logic [COEF_BITS-1:0]  numerator;
  logic [COEF_BITS-1:0]  denominator;
  logic [POWER_BITS-1:0] x_power;
  logic [POWER_BITS-1:0] y_power;
  logic [POWER_BITS-1:0] z_power;
  logic [POWER_BITS-1:0] r_power;
  logic                  final_term;

  modport source (output valid, negative, numerator, denominator, x_power, y_power,
                  z_power, r_power, final_term, input ready);
  modport sink (input valid, negative, numerator, denominator, x_power, y_power,
                z_power, r_power, final_term, output ready);
endinterface

// ===== rtl/ptp_term_step.sv =====
// Combinational next-state and term result logic for one character.
module ptp_term_step
  import ptp_pkg::*;
#(
  parameter int COEF_BITS  = COEF_BITS_DEF,
  parameter int POWER_BITS = POWER_BITS_DEF
) (
  input  logic [7:0]            character_i,
  input  logic                  final_char_i,
  input  logic [COEF_BITS-1:0]  num_i,
  input  logic [COEF_BITS-1:0]  den_i,
  input  logic [DIGIT_BITS-1:0] pdig_i,
  input  seen_t                 seen_i,
  input  logic [POWER_BITS-1:0] pow_i [LANES],
  input  letter_e               letter_i,
  input  mode_t                 mode_i,
  input  logic                  sign_i,
  output logic [COEF_BITS-1:0]  num_o,
  output logic [COEF_BITS-1:0]  den_o,
  output logic [DIGIT_BITS-1:0] pdig_o,
  output seen_t                 seen_o,
  output logic [POWER_BITS-1:0] pow_o [LANES],
  output letter_e               letter_o,
  output mode_t                 mode_o,
  output logic                  sign_o,
  output step_ctrl_t            ctrl_o,
  output logic [COEF_BITS-1:0]  res_num_o,
  output logic [COEF_BITS-1:0]  res_den_o,
  output logic [POWER_BITS-1:0] res_pow_o [LANES]
);

  localparam int SumW = ((POWER_BITS > DIGIT_BITS) ? POWER_BITS : DIGIT_BITS) + 1;

  // Multiply by ten and add a digit, saturating at all ones.
  function automatic logic [COEF_BITS-1:0] coef_acc(logic [COEF_BITS-1:0] a,
                                                    logic [3:0] d);
    logic [COEF_BITS+3:0] t;
    t = ({4'b0, a} << 3) + ({4'b0, a} << 1) + {{COEF_BITS{1'b0}}, d};
    return (t[COEF_BITS+3:COEF_BITS] != 4'b0) ? {COEF_BITS{1'b1}} : t[COEF_BITS-1:0];
  endfunction

  function automatic logic [DIGIT_BITS-1:0] digit_acc(logic [DIGIT_BITS-1:0] a,
                                                      logic [3:0] d);
    logic [DIGIT_BITS+3:0] t;
    t = ({4'b0, a} << 3) + ({4'b0, a} << 1) + {{DIGIT_BITS{1'b0}}, d};
    return (t[DIGIT_BITS+3:DIGIT_BITS] != 4'b0) ? {DIGIT_BITS{1'b1}} : t[DIGIT_BITS-1:0];
  endfunction

  // Add a power number less one to a count, clamped to the count range.
  function automatic logic [POWER_BITS-1:0] power_fold(logic [POWER_BITS-1:0] p,
                                                       logic [DIGIT_BITS-1:0] pd);
    logic [SumW-1:0] s;
    s = SumW'(p) + SumW'(pd);
    if (s == '0) return '0;
    s = s - SumW'(1);
    if (s > SumW'({POWER_BITS{1'b1}})) return {POWER_BITS{1'b1}};
    return s[POWER_BITS-1:0];
  endfunction

  logic                  is_digit, is_letter, term_end;
  logic [3:0]            digit;
  letter_e               new_letter;
  logic [COEF_BITS-1:0]  num_a, den_a;
  logic [DIGIT_BITS-1:0] pdig_a;
  seen_t                 seen_a;
  letter_e               letter_a;
  mode_t                 mode_a;
  logic [POWER_BITS-1:0] pow_ap [LANES];
  logic [POWER_BITS-1:0] pow_a [LANES];
  logic [POWER_BITS-1:0] pow_b [LANES];

  // Classify the character.
  always_comb begin
    is_digit  = (character_i >= CHAR_0) && (character_i <= CHAR_9);
    is_letter = ((character_i >= CHAR_LC_A) && (character_i <= CHAR_LC_Z)) ||
                ((character_i >= CHAR_UC_A) && (character_i <= CHAR_UC_Z));
    digit     = 4'(character_i - CHAR_0);
    term_end  = (character_i == CHAR_PLUS) || (character_i == CHAR_MINUS) || final_char_i;
    case (character_i)
      CHAR_X:  new_letter = LETTER_X;
      CHAR_Y:  new_letter = LETTER_Y;
      CHAR_Z:  new_letter = LETTER_Z;
      CHAR_R:  new_letter = LETTER_R;
      default: new_letter = LETTER_OTHER;
    endcase
  end

  // Fold pending power digits into the current letter's count.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      pow_ap[i] = (seen_i.pow && (letter_i == 3'(i + 1))) ? power_fold(pow_i[i], pdig_i)
                                                          : pow_i[i];
    end
  end

  // Apply the character to the term state.
  always_comb begin
    num_a    = num_i;
    den_a    = den_i;
    pdig_a   = pdig_i;
    seen_a   = seen_i;
    letter_a = letter_i;
    mode_a   = mode_i;
    pow_a    = pow_i;
    if (is_digit) begin
      mode_a.at_start = 1'b0;
      if (mode_i.in_num) begin
        num_a      = coef_acc(num_i, digit);
        seen_a.num = 1'b1;
      end else if (mode_i.in_den) begin
        den_a      = coef_acc(den_i, digit);
        seen_a.den = 1'b1;
      end else begin
        pdig_a     = digit_acc(pdig_i, digit);
        seen_a.pow = 1'b1;
      end
    end else if (is_letter) begin
      mode_a     = '{in_num: 1'b0, in_den: 1'b0, at_start: 1'b0};
      pdig_a     = '0;
      seen_a.pow = 1'b0;
      letter_a   = new_letter;
      for (int i = 0; i < LANES; i++) begin
        if ((new_letter == 3'(i + 1)) && (pow_ap[i] != {POWER_BITS{1'b1}})) begin
          pow_a[i] = pow_ap[i] + POWER_BITS'(1);
        end else begin
          pow_a[i] = pow_ap[i];
        end
      end
    end else if (character_i == CHAR_SLASH) begin
      mode_a.in_num = 1'b0;
      mode_a.in_den = 1'b1;
    end
  end

  // Close the term: fold power digits left at its end.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      pow_b[i] = (seen_a.pow && (letter_a == 3'(i + 1))) ? power_fold(pow_a[i], pdig_a)
                                                         : pow_a[i];
    end
  end

  // Drive the result and pick the next state.
  always_comb begin
    ctrl_o.emit       = term_end && !mode_a.at_start;
    ctrl_o.final_term = final_char_i;
    res_num_o         = seen_a.num ? num_a : COEF_BITS'(1);
    res_den_o         = seen_a.den ? den_a : COEF_BITS'(1);
    res_pow_o         = pow_b;

    num_o    = num_a;
    den_o    = den_a;
    pdig_o   = pdig_a;
    seen_o   = seen_a;
    pow_o    = pow_a;
    letter_o = letter_a;
    mode_o   = mode_a;
    sign_o   = sign_i;
    if (final_char_i || ctrl_o.emit) begin
      num_o    = '0;
      den_o    = '0;
      pdig_o   = '0;
      seen_o   = '0;
      letter_o = LETTER_NONE;
      for (int i = 0; i < LANES; i++) pow_o[i] = '0;
      mode_o   = '{in_num: 1'b1, in_den: 1'b0, at_start: mode_a.at_start};
    end
    if (character_i == CHAR_PLUS) sign_o = 1'b0;
    else if (character_i == CHAR_MINUS) sign_o = 1'b1;
    if (final_char_i) begin
      mode_o = MODE_RESET;
      sign_o = 1'b0;
    end
  end

endmodule

// ===== rtl/polynomial_term_text_parser_unit.sv =====
// Top level of the polynomial term text parser.
//
// Input channel in_i carries one ASCII character of a polynomial text per
// transfer, with final_char high on the last character of a string. Output
// channel out_o carries one finished term per transfer: sign, numerator,
// denominator, the powers of x, y, z and r, and final_term on the string's
// last term. A term leaves on '+', '-' or the final character once the
// first term has begun; other characters give no output.
// A character waits in the input register; the term that it closes is then
// loaded into the output register and transfers from there. Throughput:
// one character per cycle unless a term waits in the output register with
// out_o.ready low, set by the single pass from the input register through
// the accumulator update. The output register takes a new term in the same
// cycle that the current one is transferred. When the receiver stalls with a
// term waiting, the input register holds and in_i.ready drops once that
// register is full. Reset empties both registers and returns the parser to
// the start of a string with a positive sign.
`include "assert_macros.svh"

module polynomial_term_text_parser_unit
  import ptp_pkg::*;
#(
  parameter int COEF_BITS  = COEF_BITS_DEF,
  parameter int POWER_BITS = POWER_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ptp_in_if.sink    in_i,
  ptp_out_if.source out_o
);

  logic                  in_valid_q;
  logic [7:0]            char_q;
  logic                  final_q;
  logic                  step_fire;

  logic [COEF_BITS-1:0]  num_q, num_d, den_q, den_d;
  logic [DIGIT_BITS-1:0] pdig_q, pdig_d;
  seen_t                 seen_q, seen_d;
  logic [POWER_BITS-1:0] pow_q [LANES];
  logic [POWER_BITS-1:0] pow_d [LANES];
  letter_e               letter_q, letter_d;
  mode_t                 mode_q, mode_d;
  logic                  sign_q, sign_d;

  step_ctrl_t            ctrl;
  logic [COEF_BITS-1:0]  res_num, res_den;
  logic [POWER_BITS-1:0] res_pow [LANES];

  logic                  out_valid_q;
  logic                  neg_q, fin_term_q;
  logic [COEF_BITS-1:0]  onum_q, oden_q;
  logic [POWER_BITS-1:0] opow_q [LANES];

  // Advance the input register when the output register is free.
  assign step_fire  = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || step_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (step_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  // Capture the character on each input transfer.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      char_q  <= in_i.character;
      final_q <= in_i.final_char;
    end
  end

  ptp_term_step #(
    .COEF_BITS (COEF_BITS),
    .POWER_BITS(POWER_BITS)
  ) u_step (
    .character_i (char_q),
    .final_char_i(final_q),
    .num_i       (num_q),
    .den_i       (den_q),
    .pdig_i      (pdig_q),
    .seen_i      (seen_q),
    .pow_i       (pow_q),
    .letter_i    (letter_q),
    .mode_i      (mode_q),
    .sign_i      (sign_q),
    .num_o       (num_d),
    .den_o       (den_d),
    .pdig_o      (pdig_d),
    .seen_o      (seen_d),
    .pow_o       (pow_d),
    .letter_o    (letter_d),
    .mode_o      (mode_d),
    .sign_o      (sign_d),
    .ctrl_o      (ctrl),
    .res_num_o   (res_num),
    .res_den_o   (res_den),
    .res_pow_o   (res_pow)
  );

  // Update the term state once per processed character.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q    <= '0;
      den_q    <= '0;
      pdig_q   <= '0;
      seen_q   <= '0;
      letter_q <= LETTER_NONE;
      mode_q   <= MODE_RESET;
      sign_q   <= 1'b0;
      for (int i = 0; i < LANES; i++) pow_q[i] <= '0;
    end else if (step_fire) begin
      num_q    <= num_d;
      den_q    <= den_d;
      pdig_q   <= pdig_d;
      seen_q   <= seen_d;
      letter_q <= letter_d;
      mode_q   <= mode_d;
      sign_q   <= sign_d;
      pow_q    <= pow_d;
    end
  end

  // Load a finished term, drop it once transferred.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_fire && ctrl.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire && ctrl.emit) begin
      neg_q      <= sign_q;
      onum_q     <= res_num;
      oden_q     <= res_den;
      opow_q     <= res_pow;
      fin_term_q <= ctrl.final_term;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.negative    = neg_q;
  assign out_o.numerator   = onum_q;
  assign out_o.denominator = oden_q;
  assign out_o.x_power     = opow_q[0];
  assign out_o.y_power     = opow_q[1];
  assign out_o.z_power     = opow_q[2];
  assign out_o.r_power     = opow_q[3];
  assign out_o.final_term  = fin_term_q;

  // Digits seen in a term mean the term has begun.
  `PTP_ASSERT(a_seen_not_start, clk_i, rst_ni, !((seen_q != '0) && mode_q.at_start))
  // A final character brings the parser back to the start of a string.
  `PTP_ASSERT_NEXT(a_final_resets, clk_i, rst_ni, step_fire && final_q,
                   mode_q.at_start && !sign_q && (seen_q == '0))
  // A closed term is presented on the next cycle.
  `PTP_ASSERT_NEXT(a_emit_shows, clk_i, rst_ni, step_fire && ctrl.emit, out_o.valid)
  // An empty input register always takes a character.
  `PTP_ASSERT(a_empty_ready, clk_i, rst_ni, in_valid_q || in_i.ready)

endmodule
